### rtl/erl_pkg.sv
// ----------------------------------------------------------------------------
// erl_pkg - shared definitions for the expert residency LRU tracker
// Field widths, event codes, channel payloads and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package erl_pkg;

   localparam int POOL_SIZE_DEFAULT         = 128;
   localparam int MAX_STEP_ACCESSES_DEFAULT = 8;

   localparam int ID_W   = 7;
   localparam int KIND_W = 2;
   localparam int OCC_W  = 8;
   localparam int CAP_W  = 8;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 8'd32;

   typedef enum logic [KIND_W-1:0] {
      KIND_HIT   = 2'd0,
      KIND_MISS  = 2'd1,
      KIND_EVICT = 2'd2
   } kind_type;

   typedef struct packed {
      logic [ID_W-1:0] expert_id;
      logic            step_end;
   } req_payload_type;

   typedef struct packed {
      kind_type         event_kind;
      logic [ID_W-1:0]  event_expert;
      logic [OCC_W-1:0] occupancy;
      logic             last_result;
   } rsp_payload_type;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_MISS,
      OP_HIT,
      OP_LINK,
      OP_EVICT
   } dp_op_type;

   // link RAM read address source
   typedef enum logic [1:0] {
      RD_REQ,
      RD_ID,
      RD_HEAD
   } rd_sel_type;

   typedef struct packed {
      dp_op_type  op;
      rd_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic resident;
      logic at_tail;
      logic evict_due;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

### rtl/erl_stream_if.sv
// ----------------------------------------------------------------------------
// erl_stream_if - valid/ready stream channel
// One transfer per clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface erl_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/erl_ram.sv
// ----------------------------------------------------------------------------
// erl_ram - generic simple dual-port RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
`default_nettype none

module erl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/erl_dpath.sv
// ----------------------------------------------------------------------------
// erl_dpath - residency datapath
// Residency flags, doubly linked recency list in two link RAMs, counters,
// capacity register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module erl_dpath import erl_pkg::*; #(
   parameter int POOL_SIZE         = POOL_SIZE_DEFAULT,
   parameter int MAX_STEP_ACCESSES = MAX_STEP_ACCESSES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [CAP_W-1:0] csr_wr_data,
   input  wire req_payload_type  req_data,
   input  wire cmd_type          cmd,
   input  wire logic             rsp_ready,
   output sts_type               sts,
   output logic                  rsp_valid,
   output rsp_payload_type       rsp_data
);

   localparam int EW = $clog2(POOL_SIZE);
   localparam int CW = $clog2(POOL_SIZE + 1);
   localparam int SW = $clog2(MAX_STEP_ACCESSES + 1);
   localparam logic [SW-1:0] STEP_MAX = SW'(MAX_STEP_ACCESSES);

   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic [POOL_SIZE-1:0]   res_ff, res_in;
   logic [EW-1:0]          head_ff, head_in;
   logic [EW-1:0]          tail_ff, tail_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [SW-1:0]          step_ff, step_in;
   logic [SW-1:0]          ev_ff, ev_in;
   logic [ID_W-1:0]        id_ff, id_in;
   logic                   end_ff, end_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic [EW-1:0] xa;
   logic [EW-1:0] rd_addr;
   logic [EW-1:0] prv_q, nxt_q;
   logic          nxt_we, prv_we;
   logic [EW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd;
   logic [SW-1:0] step_inc;
   logic          in_range, at_head, at_tail, empty, over_cap;

   assign xa       = EW'(id_ff);
   assign in_range = 32'(id_ff) < POOL_SIZE;
   assign at_head  = (xa == head_ff);
   assign at_tail  = (xa == tail_ff);
   assign empty    = (cnt_ff == '0);
   assign over_cap = 32'(cnt_ff) > 32'(cap_ff);
   assign step_inc = step_ff + SW'(1);

   assign sts.in_range  = in_range;
   assign sts.resident  = in_range && res_ff[xa];
   assign sts.at_tail   = at_tail;
   assign sts.evict_due = end_ff && over_cap && (ev_ff < STEP_MAX);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_REQ:  rd_addr = EW'(req_data.expert_id);
         RD_ID:   rd_addr = xa;
         RD_HEAD: rd_addr = head_ff;
         default: rd_addr = xa;
      endcase
   end

   // next pointers
   erl_ram #(.WIDTH(EW), .DEPTH(POOL_SIZE)) u_nxt_ram (
      .clock   (clock),
      .wr_en   (nxt_we),
      .wr_addr (nxt_wa),
      .wr_data (nxt_wd),
      .rd_addr (rd_addr),
      .rd_data (nxt_q)
   );

   // previous pointers
   erl_ram #(.WIDTH(EW), .DEPTH(POOL_SIZE)) u_prv_ram (
      .clock   (clock),
      .wr_en   (prv_we),
      .wr_addr (prv_wa),
      .wr_data (prv_wd),
      .rd_addr (rd_addr),
      .rd_data (prv_q)
   );

   always_comb begin
      cap_in       = cap_ff;
      res_in       = res_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      ev_in        = ev_ff;
      id_in        = id_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      nxt_we       = 1'b0;
      nxt_wa       = tail_ff;
      nxt_wd       = xa;
      prv_we       = 1'b0;
      prv_wa       = xa;
      prv_wd       = tail_ff;

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end

      unique case (cmd.op)
         OP_ACCEPT: begin
            id_in   = req_data.expert_id;
            end_in  = req_data.step_end || (step_inc >= STEP_MAX);
            step_in = end_in ? '0 : step_inc;
            ev_in   = '0;
         end
         OP_MISS: begin
            // append at the recent end
            if (empty) begin
               head_in = xa;
            end else begin
               nxt_we = 1'b1;
               prv_we = 1'b1;
            end
            tail_in                  = xa;
            res_in[xa]               = 1'b1;
            cnt_in                   = cnt_ff + CW'(1);
            rsp_valid_in             = 1'b1;
            rsp_data_in.event_kind   = KIND_MISS;
            rsp_data_in.event_expert = id_ff;
            rsp_data_in.occupancy    = OCC_W'(cnt_ff + CW'(1));
            rsp_data_in.last_result  = !(end_ff && (32'(cnt_ff) >= 32'(cap_ff)));
         end
         OP_HIT: begin
            // unlink; relinked at the tail by OP_LINK
            if (!at_tail) begin
               prv_we = 1'b1;
               prv_wa = nxt_q;
               prv_wd = prv_q;
               if (at_head) begin
                  head_in = nxt_q;
               end else begin
                  nxt_we = 1'b1;
                  nxt_wa = prv_q;
                  nxt_wd = nxt_q;
               end
            end
            rsp_valid_in             = 1'b1;
            rsp_data_in.event_kind   = KIND_HIT;
            rsp_data_in.event_expert = id_ff;
            rsp_data_in.occupancy    = OCC_W'(cnt_ff);
            rsp_data_in.last_result  = !(end_ff && over_cap);
         end
         OP_LINK: begin
            nxt_we  = 1'b1;
            prv_we  = 1'b1;
            tail_in = xa;
         end
         OP_EVICT: begin
            res_in[head_ff]          = 1'b0;
            head_in                  = nxt_q;
            cnt_in                   = cnt_ff - CW'(1);
            ev_in                    = ev_ff + SW'(1);
            rsp_valid_in             = 1'b1;
            rsp_data_in.event_kind   = KIND_EVICT;
            rsp_data_in.event_expert = ID_W'(head_ff);
            rsp_data_in.occupancy    = OCC_W'(cnt_ff - CW'(1));
            rsp_data_in.last_result  = !((32'(cnt_ff) > 32'(cap_ff) + 32'd1) &&
                                         ((ev_ff + SW'(1)) < STEP_MAX));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAPACITY_RESET;
         res_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         cnt_ff       <= '0;
         step_ff      <= '0;
         ev_ff        <= '0;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         res_ff       <= res_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         ev_ff        <= ev_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      id_ff       <= id_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/erl_ctrl.sv
// ----------------------------------------------------------------------------
// erl_ctrl - sequencing controller
// Steps each access through lookup, list update and step-end evictions.
// ----------------------------------------------------------------------------
`default_nettype none

module erl_ctrl import erl_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_LINK,
      S_EVCHK,
      S_EVICT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      cmd.rd_sel = RD_ID;
      unique case (state_ff)
         S_IDLE: begin
            cmd.rd_sel = RD_REQ;
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!sts.in_range) begin
               state_in = S_EVCHK;
            end else if (sts.out_free) begin
               if (sts.resident) begin
                  cmd.op   = OP_HIT;
                  state_in = sts.at_tail ? S_EVCHK : S_LINK;
               end else begin
                  cmd.op   = OP_MISS;
                  state_in = S_EVCHK;
               end
            end
         end
         S_LINK: begin
            cmd.op   = OP_LINK;
            state_in = S_EVCHK;
         end
         S_EVCHK: begin
            cmd.rd_sel = RD_HEAD;
            state_in   = sts.evict_due ? S_EVICT : S_IDLE;
         end
         S_EVICT: begin
            cmd.rd_sel = RD_HEAD;
            if (sts.out_free) begin
               cmd.op   = OP_EVICT;
               state_in = S_EVCHK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

### rtl/expert_residency_lru.sv
// ----------------------------------------------------------------------------
// expert_residency_lru - expert residency tracker in least-recently-used order
// Reports hit/miss per access and evicts the oldest experts at step end
// while occupancy exceeds the programmed capacity, up to MAX_STEP_ACCESSES per step.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake           Carries
//  req_chan  in   valid/ready         expert_id, step_end
//  rsp_chan  out  valid/ready         event_kind, event_expert, occupancy,
//                                     last_result
//  csr_*     in   csr_wr_en only      capacity (8 bits, reset 32)
//
//  Steps: accept, lookup, eviction check; a hit on any but the most recent
//  expert adds a relink step, and each eviction at step end adds an evict
//  step and a new check. The single write port of each link RAM and the
//  registered RAM read that precedes every list update set this sequence.
//  Reset: synchronous; residency flags live in flip-flops, so no clearing
//  pass is run and the block takes a transfer in the first cycle after reset.
//  Stalls: one result register; the controller waits only when it must emit
//  and that register is still held by a stalled rsp_chan.
// ----------------------------------------------------------------------------
`default_nettype none

module expert_residency_lru import erl_pkg::*; #(
   parameter int POOL_SIZE         = POOL_SIZE_DEFAULT,
   parameter int MAX_STEP_ACCESSES = MAX_STEP_ACCESSES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [CAP_W-1:0] csr_wr_data,
   erl_stream_if.sink            req_chan,
   erl_stream_if.source          rsp_chan
);

   cmd_type cmd;     // controller -> datapath
   sts_type sts;     // datapath -> controller

   erl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // the datapath samples the request payload on OP_ACCEPT, i.e. on a transfer
   erl_dpath #(
      .POOL_SIZE         (POOL_SIZE),
      .MAX_STEP_ACCESSES (MAX_STEP_ACCESSES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_chan.payload),
      .cmd         (cmd),
      .rsp_ready   (rsp_chan.ready),
      .sts         (sts),
      .rsp_valid   (rsp_chan.valid),
      .rsp_data    (rsp_chan.payload)
   );

   // an accepted access keeps the input closed for at least the next cycle
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("input open in the cycle after a transfer");

   // a result is only loaded when the result register is free
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_HIT || cmd.op == OP_MISS || cmd.op == OP_EVICT) |->
      (!rsp_chan.valid || rsp_chan.ready))
      else $error("result register overwritten");

   // an eviction only happens at step end, above capacity, within the limit
   a_evict_due: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EVICT |-> sts.evict_due)
      else $error("eviction without cause");

endmodule

`default_nettype wire

### test/lru_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_event_checker - result predictor and comparator for the residency LRU
// Follows every request transfer, predicts the hit, miss and eviction events
// it causes and compares each response transfer against the oldest one due.
// ----------------------------------------------------------------------------

module lru_event_checker import erl_pkg::*; #(
   parameter int POOL_SIZE         = POOL_SIZE_DEFAULT,
   parameter int MAX_STEP_ACCESSES = MAX_STEP_ACCESSES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data,
   input  logic             req_valid,
   input  logic             req_ready,
   input  req_payload_type  req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsp_payload_type  rsp_payload,
   output int               error_count,
   output int               outstanding
);

   logic [CAP_W-1:0] capacity;
   logic [ID_W-1:0]  lru_order[$];      // oldest expert at the front
   bit               resident[POOL_SIZE];
   int               step_count;
   rsp_payload_type  due_events[$];

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   function automatic rsp_payload_type make_event(input kind_type kind,
                                                  input logic [ID_W-1:0] who);
      rsp_payload_type ev;
      ev.event_kind   = kind;
      ev.event_expert = who;
      ev.occupancy    = OCC_W'(lru_order.size());
      ev.last_result  = 1'b0;
      return ev;
   endfunction

   function automatic void apply_access(input req_payload_type acc);
      rsp_payload_type batch[$];
      rsp_payload_type tail_ev;
      logic [ID_W-1:0] victim;
      int              pos;
      int              evicted;
      int              next_count;
      logic            closes;
      pos     = 0;
      evicted = 0;
      if (int'(acc.expert_id) < POOL_SIZE) begin
         if (resident[acc.expert_id]) begin
            while (lru_order[pos] != acc.expert_id) pos++;
            lru_order.delete(pos);
            lru_order = {lru_order, acc.expert_id};
            batch = {batch, make_event(KIND_HIT, acc.expert_id)};
         end else if (lru_order.size() < POOL_SIZE) begin
            lru_order = {lru_order, acc.expert_id};
            resident[acc.expert_id] = 1'b1;
            batch = {batch, make_event(KIND_MISS, acc.expert_id)};
         end
      end
      // step closes on the flag or on the access cap
      next_count = step_count + 1;
      closes     = acc.step_end || (next_count >= MAX_STEP_ACCESSES);
      step_count = closes ? 0 : next_count;
      if (closes) begin
         while (lru_order.size() > int'(capacity) && evicted < MAX_STEP_ACCESSES) begin
            victim = lru_order[0];
            lru_order.delete(0);
            resident[victim] = 1'b0;
            evicted++;
            batch = {batch, make_event(KIND_EVICT, victim)};
         end
      end
      if (batch.size() > 0) begin
         tail_ev = batch[batch.size() - 1];
         tail_ev.last_result = 1'b1;
         batch[batch.size() - 1] = tail_ev;
      end
      due_events = {due_events, batch};
   endfunction

   function automatic void compare_event(input rsp_payload_type got);
      rsp_payload_type want;
      if (due_events.size() == 0) begin
         $error("unexpected result: event_kind %0d event_expert %0d occupancy %0d",
                got.event_kind, got.event_expert, got.occupancy);
         error_count++;
      end else begin
         want = due_events[0];
         due_events.delete(0);
         if (got.event_kind !== want.event_kind) begin
            $error("event_kind: expected %0d, actual %0d", want.event_kind, got.event_kind);
            error_count++;
         end
         if (got.event_expert !== want.event_expert) begin
            $error("event_expert: expected %0d, actual %0d",
                   want.event_expert, got.event_expert);
            error_count++;
         end
         if (got.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
            error_count++;
         end
         if (got.last_result !== want.last_result) begin
            $error("last_result: expected %0d, actual %0d",
                   want.last_result, got.last_result);
            error_count++;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         capacity   = CAPACITY_RESET;
         step_count = 0;
         lru_order.delete();
         due_events.delete();
         foreach (resident[i]) resident[i] = 1'b0;
      end else begin
         if (csr_wr_en) capacity = csr_wr_data;
         // responses in flight always stem from older requests
         if (rsp_valid && rsp_ready) compare_event(rsp_payload);
         if (req_valid && req_ready) apply_access(req_payload);
      end
      outstanding = due_events.size();
   end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - top level for the expert residency LRU tracker
// Drives access streams with random gaps and capacity settings, applies
// random back-pressure on rsp_chan and reports the event checker's verdict.
// ----------------------------------------------------------------------------

module testbench import erl_pkg::*; ();

   localparam int IDLE_LIMIT   = 4000;   // cycles without any transfer
   localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
   localparam int SETTLE       = 10;     // quiet cycles before a csr write
   localparam int TAIL_CYCLES  = 40;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 44;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   int error_count;
   int outstanding;
   int hold_req  = 0;   // bumped by stimulus, served by the receiver
   int hold_done = 0;
   bit sender_steady = 1'b0;

   erl_stream_if #(.payload_type(req_payload_type)) req_chan ();
   erl_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   expert_residency_lru u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   lru_event_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_payload (req_chan.payload),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   // One access offered from a falling edge until its transfer; returns at
   // the next falling edge with valid still high.
   task automatic send_access(input logic [ID_W-1:0] id, input logic fin);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= '{expert_id: id, step_end: fin};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Capacity only changes once every due event has been seen, so the
   // sender pauses here until the tracker has drained.
   task automatic set_capacity(input logic [CAP_W-1:0] value);
      req_chan.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Receiver: random stalls, occasional steady stretches, and a long
   // hold-off whenever the stimulus asks for one.
   initial begin
      int stall;
      int steady_left;
      steady_left   = 0;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_req != hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done++;
         end else begin
            if (steady_left > 0) begin
               steady_left--;
               stall = 0;
            end else begin
               if ($urandom_range(0, 99) < 3) steady_left = $urandom_range(40, 120);
               stall = pick_gap();
            end
            if (stall > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_chan.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Watchdog: gives up after a long run with no transfer on either channel
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Stimulus
   initial begin
      logic [CAP_W-1:0] cap;
      logic [ID_W-1:0]  base;
      logic [ID_W-1:0]  id;
      int               window;
      int               sent;
      int               len;
      logic             fin;

      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed part ---------------------------------------------------
      set_capacity(8'd2);
      send_access(7'd0,   1'b0);            // miss
      send_access(7'd127, 1'b0);            // miss
      send_access(7'd127, 1'b0);            // hit on the most recent expert
      send_access(7'd0,   1'b0);            // hit deeper in the list
      send_access(7'd5,   1'b1);            // step end, one eviction
      // eight accesses with no step_end flag: the cap closes the step
      for (int k = 0; k < 8; k++) send_access(ID_W'(40 + k), 1'b0);
      // zero capacity: everything resident goes
      set_capacity(8'd0);
      send_access(7'd46, 1'b1);
      // capacity beyond the pool: no eviction at all
      set_capacity(8'd255);
      for (int k = 0; k < 11; k++) send_access(ID_W'(20 + k), 1'b0);
      // capacity dropped to one: eviction limit per step, excess carried over
      set_capacity(8'd1);
      send_access(7'd31,  1'b1);
      send_access(7'd127, 1'b1);

      // --- random part ------------------------------------------------------
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: cap = 8'd128;
            1: cap = 8'd1;
            2: cap = 8'd0;
            3: cap = 8'd255;
            6: cap = 8'd8;
            8: cap = 8'd128;
            9: cap = 8'd3;
            default: cap = CAP_W'($urandom_range(1, 128));
         endcase
         set_capacity(cap);
         sender_steady = (ph == 2 || ph == 4 || ph == 7);
         // long receiver hold while the sender keeps offering
         if (ph == 4) hold_req++;
         // working set a little larger than capacity, so hits and evictions mix
         window = (cap == 0) ? 4 : ((int'(cap) + int'(cap) / 4 + 2 > 128) ? 128 :
                  int'(cap) + int'(cap) / 4 + 2);
         base = ID_W'($urandom_range(0, 127));
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 99) < 80)
                  id = ID_W'(int'(base) + $urandom_range(0, window - 1));
               else
                  id = ID_W'($urandom_range(0, 127));
               // most steps carry the flag on their last access; the rest
               // run on and are closed by the cap
               fin = (k == len - 1) && ($urandom_range(0, 99) < 85);
               send_access(id, fin);
               sent++;
            end
         end
      end

      // --- drain and verdict -----------------------------------------------
      req_chan.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
